// File: src/cbt_pkg.sv
// Shared types and constants for the crit-bit reference-counted table.
`timescale 1ns / 1ps
package cbt_pkg;

   localparam int KEY_W = 256;
   localparam int HANDLE_W = 10;
   localparam int CNT_OUT_W = 16;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_DEAD      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_EMPTY  = 2'd0,
      KIND_LEAF   = 2'd1,
      KIND_BRANCH = 2'd2
   } kind_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_INIT,
      S_DISPATCH,
      S_WALK_RD,
      S_WALK,
      S_LEAF_RD,
      S_CMP,
      S_DIFF,
      S_INS_RD,
      S_INS,
      S_INS_LINK,
      S_REL_RD,
      S_REL,
      S_REL_WALK_RD,
      S_REL_WALK,
      S_REL_SPLICE,
      S_RESP
   } state_type;

endpackage

// File: src/critbit_tree_refcounted_table.sv
// Top level: crit-bit tree of reference-counted entries keyed by a digest.
`timescale 1ns / 1ps
// Each request walks the tree held in synchronous memories (one read and one
// write port each), one node at a time (address, then registered read
// data). An acquire walks once to a leaf, compares the key (up to KEY_BYTES
// bytes, one byte a cycle), and for a new key walks a second time to the
// insertion point; a release walks from the root to the parent of the leaf.
// After reset a clearing pass loads the free lists and zeroes every count
// (a zero count marks a dead slot), during which no request is accepted.
// One result per request leaves through an output register; no request is
// taken while it waits.
module critbit_tree_refcounted_table #(
   parameter int MAX_ENTRIES = 1024,
   parameter int KEY_BYTES   = 32,
   parameter int COUNT_BITS  = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: req_type[0], key_w0[64:1], key_w1[128:65], key_w2[192:129],
   // key_w3[256:193], release_handle[266:257], zero fill to 272
   input  logic [271:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: entry_handle[9:0], created[10], removed[11], ref_count[27:12],
   // status[29:28], zero fill to 32
   output logic [31:0]  rsp_tdata
);
   import cbt_pkg::*;

   localparam int LW  = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
   localparam int NB  = MAX_ENTRIES - 1;
   localparam int BW  = (NB > 1) ? $clog2(NB) : 1;
   localparam int IW  = (LW > BW) ? LW : BW;
   localparam int RW  = 2 + IW;
   localparam int CW  = $clog2(KEY_BYTES * 8);
   localparam int UW  = $clog2(KEY_BYTES + 1);
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   typedef logic [RW-1:0] ref_type;

   // memories
   logic [KEY_W-1:0]       key_mem   [MAX_ENTRIES];
   logic [COUNT_BITS-1:0]  cnt_mem   [MAX_ENTRIES];
   logic [CW-1:0]          crit_mem  [NB];
   logic [2*RW-1:0]        kids_mem  [NB];
   logic [LW-1:0]          lfree_mem [MAX_ENTRIES];
   logic [BW-1:0]          bfree_mem [NB];

   // control and working registers
   state_type state_ff, state_in;
   logic [LW:0]      init_ff, init_in;
   logic [LW:0]      ltot_ff, ltot_in;
   logic [BW:0]      btot_ff, btot_in;
   ref_type          root_ff, root_in;
   logic             op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [HANDLE_W-1:0] hnd_ff, hnd_in;
   ref_type          cur_ff, cur_in;       // node being visited
   ref_type          par_ff, par_in;       // parent branch ref (kind EMPTY = root)
   logic             pside_ff, pside_in;
   logic [UW-1:0]    u_ff, u_in;
   logic [CW-1:0]    crit_ff, crit_in;
   logic [LW-1:0]    nl_ff, nl_in;
   logic [BW-1:0]    nbr_ff, nbr_in;
   logic [CW-1:0]    rd_crit_ff;
   logic [2*RW-1:0]  rd_kids_ff;
   logic [KEY_W-1:0] rd_key_ff;
   logic [COUNT_BITS-1:0] rd_cnt_ff;
   logic [LW-1:0]    rd_lfree_ff;
   logic [BW-1:0]    rd_bfree_ff;
   logic             rsp_v_ff, rsp_v_in;
   logic [31:0]      rsp_d_ff, rsp_d_in;

   // memory ports
   logic [BW-1:0] br_addr;
   logic [LW-1:0] lf_addr;
   logic          crit_we, kids_we, key_we, cnt_we, lfree_we, bfree_we;
   logic [BW-1:0] bw_addr, bfree_waddr, bfree_raddr;
   logic [LW-1:0] lw_addr, lfree_waddr, lfree_raddr;
   logic [CW-1:0] crit_wd;
   logic [2*RW-1:0] kids_wd;
   logic [COUNT_BITS-1:0] cnt_wd;
   logic [LW-1:0] lfree_wd;
   logic [BW-1:0] bfree_wd;

   // Key bit at a crit position, MSB first from byte 0.
   function automatic logic kbit(input logic [KEY_W-1:0] k, input logic [CW-1:0] c);
      logic [7:0] bi;
      bi = 8'(KEY_W - 1) - 8'(c);
      return k[bi];
   endfunction

   function automatic logic [7:0] kbyte(input logic [KEY_W-1:0] k, input logic [UW-1:0] i);
      logic [4:0] j;
      j = 5'(i);
      return k[KEY_W-1 - 8*j -: 8];
   endfunction

   function automatic ref_type mkref(input kind_type k, input logic [IW-1:0] i);
      return {k, i};
   endfunction

   // Memory storage and registered reads.
   always_ff @(posedge clock) begin
      if (crit_we) crit_mem[bw_addr] <= crit_wd;
      if (kids_we) kids_mem[bw_addr] <= kids_wd;
      if (key_we) key_mem[lw_addr] <= key_ff;
      if (cnt_we) cnt_mem[lw_addr] <= cnt_wd;
      if (lfree_we) lfree_mem[lfree_waddr] <= lfree_wd;
      if (bfree_we) bfree_mem[bfree_waddr] <= bfree_wd;
      rd_crit_ff  <= crit_mem[br_addr];
      rd_kids_ff  <= kids_mem[br_addr];
      rd_key_ff   <= key_mem[lf_addr];
      rd_cnt_ff   <= cnt_mem[lf_addr];
      rd_lfree_ff <= lfree_mem[lfree_raddr];
      rd_bfree_ff <= bfree_mem[bfree_raddr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff  <= '0;
         ltot_ff  <= (LW+1)'(MAX_ENTRIES);
         btot_ff  <= (BW+1)'(NB);
         root_ff  <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         ltot_ff  <= ltot_in;
         btot_ff  <= btot_in;
         root_ff  <= root_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff <= op_in; key_ff <= key_in; hnd_ff <= hnd_in;
      cur_ff <= cur_in; par_ff <= par_in; pside_ff <= pside_in;
      u_ff <= u_in; crit_ff <= crit_in; nl_ff <= nl_in; nbr_ff <= nbr_in;
      rsp_d_ff <= rsp_d_in;
   end

   logic [7:0] xb;
   logic [2:0] rb;
   logic       cur_br, cur_lf, s_bit, key_mask_ok;
   ref_type    kid_s, kid_o;
   logic [KEY_W-1:0] in_key;

   always_comb begin
      in_key = {req_tdata[64:1], req_tdata[128:65], req_tdata[192:129], req_tdata[256:193]};
      cur_br = (cur_ff[RW-1 -: 2] == KIND_BRANCH) && (cur_ff[IW-1:0] < IW'(NB));
      cur_lf = (cur_ff[RW-1 -: 2] == KIND_LEAF) &&
               ({1'b0, cur_ff[IW-1:0]} < (IW+1)'(MAX_ENTRIES));
      xb = kbyte(key_ff, u_ff) ^ kbyte(rd_key_ff, u_ff);
      rb = 3'd7;
      for (int i = 6; i >= 0; i--) if (xb[7-i]) rb = 3'(i);
      s_bit = kbit((op_ff ? rd_key_ff : key_ff), rd_crit_ff);
      kid_s = s_bit ? rd_kids_ff[2*RW-1:RW] : rd_kids_ff[RW-1:0];
      kid_o = s_bit ? rd_kids_ff[RW-1:0] : rd_kids_ff[2*RW-1:RW];
      key_mask_ok = (kbyte(key_ff, u_ff) == kbyte(rd_key_ff, u_ff));
   end

   // Sequencer: next state, memory controls and result.
   always_comb begin
      state_in = state_ff; init_in = init_ff; ltot_in = ltot_ff; btot_in = btot_ff;
      root_in = root_ff; op_in = op_ff; key_in = key_ff; hnd_in = hnd_ff;
      cur_in = cur_ff; par_in = par_ff; pside_in = pside_ff; u_in = u_ff;
      crit_in = crit_ff; nl_in = nl_ff; nbr_in = nbr_ff;
      rsp_v_in = rsp_v_ff; rsp_d_in = rsp_d_ff;
      // a release keeps the handle's key on the leaf read port for its walk
      br_addr = cur_ff[BW-1:0]; lf_addr = op_ff ? hnd_ff[LW-1:0] : cur_ff[LW-1:0];
      crit_we = 1'b0; kids_we = 1'b0; key_we = 1'b0; cnt_we = 1'b0;
      lfree_we = 1'b0; bfree_we = 1'b0;
      bw_addr = nbr_ff; lw_addr = nl_ff; crit_wd = crit_ff; kids_wd = '0; cnt_wd = '0;
      lfree_waddr = init_ff[LW-1:0]; lfree_wd = LW'(MAX_ENTRIES - 1) - init_ff[LW-1:0];
      bfree_waddr = init_ff[BW-1:0]; bfree_wd = BW'(NB - 1) - init_ff[BW-1:0];
      lfree_raddr = LW'(ltot_ff - 1'b1); bfree_raddr = BW'(btot_ff - 1'b1);
      req_tready = 1'b0;

      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;

      unique case (state_ff)
         // Load both free stacks and zero the counts, one entry a cycle.
         S_INIT: begin
            lfree_we = 1'b1;
            bfree_we = (init_ff < (LW+1)'(NB));
            cnt_we = 1'b1; lw_addr = init_ff[LW-1:0];
            init_in = init_ff + 1'b1;
            if (init_ff == (LW+1)'(MAX_ENTRIES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = !rsp_v_ff;
            if (req_tvalid && req_tready) begin
               op_in = req_tdata[0];
               key_in = in_key;
               for (int i = 0; i < 32; i++)
                  if (i >= KEY_BYTES) key_in[KEY_W-1-8*i -: 8] = 8'd0;
               hnd_in = req_tdata[266:257];
               cur_in = root_ff;
               par_in = '0; pside_in = 1'b0;
               u_in = '0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (op_ff) begin
               lf_addr = hnd_ff[LW-1:0];
               if (32'(hnd_ff) >= MAX_ENTRIES) begin
                  rsp_d_in = {2'b0, ST_DEAD, 16'd0, 1'b0, 1'b0, hnd_ff};
                  state_in = S_RESP;
               end else state_in = S_REL;
            end else if (root_ff[RW-1 -: 2] == KIND_EMPTY) begin
               if (ltot_ff == '0) begin
                  rsp_d_in = {2'b0, ST_FULL, 28'd0};
                  state_in = S_RESP;
               end else state_in = S_INS_RD;
            end else state_in = S_WALK_RD;
         end
         // First walk: follow crit bits to a leaf.
         S_WALK_RD: begin
            if (cur_br) state_in = S_WALK;
            else if (cur_lf) state_in = S_LEAF_RD;
            else begin
               rsp_d_in = {2'b0, ST_FULL, 28'd0};
               state_in = S_RESP;
            end
         end
         S_WALK: begin
            br_addr = cur_ff[BW-1:0];
            cur_in = kid_s;
            state_in = S_WALK_RD;
         end
         S_LEAF_RD: state_in = S_CMP;
         // Compare one key byte a cycle.
         S_CMP: begin
            if (u_ff == UW'(KEY_BYTES)) begin
               cnt_wd = (rd_cnt_ff == CMAX) ? rd_cnt_ff : rd_cnt_ff + 1'b1;
               cnt_we = 1'b1; lw_addr = cur_ff[LW-1:0];
               rsp_d_in = {2'b0, ST_OK, CNT_OUT_W'(cnt_wd), 1'b0, 1'b0,
                           HANDLE_W'(cur_ff[LW-1:0])};
               state_in = S_RESP;
            end else if (key_mask_ok) u_in = u_ff + 1'b1;
            else state_in = S_DIFF;
         end
         S_DIFF: begin
            if (ltot_ff == '0 || btot_ff == '0) begin
               rsp_d_in = {2'b0, ST_FULL, 28'd0};
               state_in = S_RESP;
            end else begin
               crit_in = CW'({u_ff, 3'b000}) + CW'(rb);
               cur_in = root_ff;
               state_in = S_INS_RD;
            end
         end
         // Pop free slots (data arrives next cycle) and write the new leaf.
         S_INS_RD: state_in = S_INS;
         S_INS: begin
            nl_in = rd_lfree_ff;
            nbr_in = rd_bfree_ff;
            ltot_in = ltot_ff - 1'b1;
            lw_addr = rd_lfree_ff; key_we = 1'b1; cnt_we = 1'b1;
            cnt_wd = COUNT_BITS'(1);
            if (root_ff[RW-1 -: 2] == KIND_EMPTY) begin
               root_in = mkref(KIND_LEAF, IW'(rd_lfree_ff));
               rsp_d_in = {2'b0, ST_OK, 16'd1, 1'b0, 1'b1, HANDLE_W'(rd_lfree_ff)};
               state_in = S_RESP;
            end else begin
               btot_in = btot_ff - 1'b1;
               bw_addr = rd_bfree_ff; crit_we = 1'b1;
               state_in = S_INS_LINK;
               cur_in = root_ff;
               par_in = '0;
            end
         end
         // Second walk: find the first node with crit larger, then link.
         S_INS_LINK: begin
            if (cur_br && u_ff != '1) begin
               br_addr = cur_ff[BW-1:0];
               u_in = '1;          // read issued; examine next cycle
            end else if (cur_br && rd_crit_ff <= crit_ff) begin
               par_in = cur_ff; pside_in = s_bit;
               cur_in = kid_s;
               u_in = '0;
            end else begin
               // new branch: own leaf on our side, displaced subtree opposite
               bw_addr = nbr_ff; kids_we = 1'b1;
               kids_wd = kbit(key_ff, crit_ff)
                  ? {mkref(KIND_LEAF, IW'(nl_ff)), cur_ff}
                  : {cur_ff, mkref(KIND_LEAF, IW'(nl_ff))};
               if (par_ff[RW-1 -: 2] == KIND_EMPTY) begin
                  root_in = mkref(KIND_BRANCH, IW'(nbr_ff));
                  rsp_d_in = {2'b0, ST_OK, 16'd1, 1'b0, 1'b1, HANDLE_W'(nl_ff)};
                  state_in = S_RESP;
               end else begin
                  cur_in = mkref(KIND_BRANCH, IW'(nbr_ff));
                  br_addr = par_ff[BW-1:0];
                  state_in = S_REL_SPLICE;
               end
            end
         end
         // Release: read count and key of the handle.
         S_REL: begin
            lf_addr = hnd_ff[LW-1:0];
            state_in = S_REL_RD;
         end
         S_REL_RD: begin
            cnt_wd = rd_cnt_ff - 1'b1;
            cnt_we = 1'b1; lw_addr = hnd_ff[LW-1:0];
            if (rd_cnt_ff == '0) begin
               cnt_we = 1'b0;
               rsp_d_in = {2'b0, ST_DEAD, 16'd0, 1'b0, 1'b0, hnd_ff};
               state_in = S_RESP;
            end else if (cnt_wd != '0) begin
               rsp_d_in = {2'b0, ST_OK, CNT_OUT_W'(cnt_wd), 1'b0, 1'b0, hnd_ff};
               state_in = S_RESP;
            end else begin
               lfree_we = 1'b1; lfree_waddr = ltot_ff[LW-1:0]; lfree_wd = hnd_ff[LW-1:0];
               ltot_in = ltot_ff + 1'b1;
               rsp_d_in = {2'b0, ST_OK, 16'd0, 1'b1, 1'b0, hnd_ff};
               if (root_ff == mkref(KIND_LEAF, IW'(hnd_ff))) begin
                  root_in = '0;
                  state_in = S_RESP;
               end else begin
                  cur_in = root_ff; par_in = '0;
                  state_in = S_REL_WALK_RD;
               end
            end
         end
         S_REL_WALK_RD: begin
            br_addr = cur_ff[BW-1:0];
            if (cur_br) state_in = S_REL_WALK;
            else state_in = S_RESP;
         end
         S_REL_WALK: begin
            br_addr = cur_ff[BW-1:0];
            if (kid_s == mkref(KIND_LEAF, IW'(hnd_ff))) begin
               bfree_we = (btot_ff < (BW+1)'(NB));
               bfree_waddr = btot_ff[BW-1:0]; bfree_wd = cur_ff[BW-1:0];
               if (btot_ff < (BW+1)'(NB)) btot_in = btot_ff + 1'b1;
               cur_in = kid_o;
               if (par_ff[RW-1 -: 2] == KIND_EMPTY) begin
                  root_in = kid_o;
                  state_in = S_RESP;
               end else begin
                  br_addr = par_ff[BW-1:0];
                  state_in = S_REL_SPLICE;
               end
            end else begin
               par_in = cur_ff; pside_in = s_bit;
               cur_in = kid_s;
               state_in = S_REL_WALK_RD;
            end
         end
         // Rewrite one child slot of the parent with cur (read-modify-write).
         S_REL_SPLICE: begin
            br_addr = par_ff[BW-1:0];
            if (u_ff != '0 && !op_ff) u_in = '0;
            else if (u_ff == '0 && !op_ff) u_in = UW'(1);
            if (op_ff || u_ff == UW'(1)) begin
               bw_addr = par_ff[BW-1:0]; kids_we = 1'b1;
               kids_wd = pside_ff ? {cur_ff, rd_kids_ff[RW-1:0]}
                                  : {rd_kids_ff[2*RW-1:RW], cur_ff};
               if (!op_ff) rsp_d_in = {2'b0, ST_OK, 16'd1, 1'b0, 1'b1, HANDLE_W'(nl_ff)};
               state_in = S_RESP;
            end
            if (op_ff && u_ff != UW'(2)) begin
               kids_we = 1'b0; u_in = UW'(2); state_in = S_REL_SPLICE;
            end
         end
         S_RESP: begin
            rsp_v_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

`ifndef SYNTHESIS
   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> !req_tready) else $error("accept during clearing pass");
   a_result_after_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |=> rsp_tvalid) else $error("result lost");
   a_free_bounds: assert property (@(posedge clock) disable iff (reset)
      (ltot_ff <= (LW+1)'(MAX_ENTRIES)) && (btot_ff <= (BW+1)'(NB)))
      else $error("free count out of range");
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
`endif

endmodule

// File: verif/critbit_tree_refcounted_table_test.sv
// Self-checking testbench for the crit-bit reference-counted table.
`timescale 1ns / 1ps
module critbit_tree_refcounted_table_test;
   import cbt_pkg::*;

   localparam int NUM_SLOTS  = 1024;
   localparam int NUM_NODES  = NUM_SLOTS - 1;
   localparam int COUNT_TOP  = 65535;
   localparam int QUIET_MAX  = 20000;
   localparam int DRAIN_WAIT = 200;

   localparam logic REQ_ACQUIRE = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] idx;
   } node_ref_t;

   typedef struct packed {
      logic                 kind;
      logic [255:0]         digest;
      logic [HANDLE_W-1:0]  handle;
   } request_t;

   typedef struct packed {
      logic [HANDLE_W-1:0]  handle;
      logic                 created;
      logic                 removed;
      logic [CNT_OUT_W-1:0] count;
      status_type           status;
   } outcome_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [271:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;

   critbit_tree_refcounted_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // shadow of the table
   node_ref_t   root_ref;
   logic [7:0]  node_crit [NUM_NODES];
   node_ref_t   node_kid [NUM_NODES][2];
   logic [255:0] slot_digest [NUM_SLOTS];
   int unsigned slot_count [NUM_SLOTS];
   bit          slot_live [NUM_SLOTS];
   int          slot_free [NUM_SLOTS];
   int          node_free [NUM_NODES];
   int          slot_free_top;
   int          node_free_top;

   request_t pending_q[$];
   outcome_t planned_q[$];
   outcome_t awaited_q[$];
   outcome_t shown_outcome;

   int  total_items;
   int  accepted;
   int  quiet_cycles;
   int  mismatches;
   int  send_idle;
   int  take_idle;
   bit  run_over;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic digest_bit(logic [255:0] d, int crit);
      return d[255 - crit];
   endfunction

   function automatic node_ref_t mk_ref(kind_type k, int i);
      node_ref_t r;
      r.kind = k;
      r.idx  = 16'(i);
      return r;
   endfunction

   function automatic logic [255:0] random_digest();
      logic [255:0] d;
      for (int i = 0; i < 8; i++) d[i*32 +: 32] = $urandom;
      return d;
   endfunction

   function automatic void table_clear();
      root_ref = mk_ref(KIND_EMPTY, 0);
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_live[i]  = 1'b0;
         slot_count[i] = 0;
         slot_free[i]  = NUM_SLOTS - 1 - i;
      end
      for (int i = 0; i < NUM_NODES; i++) node_free[i] = NUM_NODES - 1 - i;
      slot_free_top = NUM_SLOTS;
      node_free_top = NUM_NODES;
   endfunction

   // write a link: the root when parent is negative, else a child of a branch
   function automatic void set_link(int parent, int side, node_ref_t v);
      if (parent < 0) root_ref = v;
      else node_kid[parent][side] = v;
   endfunction

   function automatic outcome_t table_acquire(logic [255:0] d);
      outcome_t  o;
      node_ref_t cur;
      node_ref_t leaf;
      logic [255:0] diff;
      int l, nb, crit, s, parent, side;
      o = '{handle: '0, created: 1'b0, removed: 1'b0, count: '0, status: ST_FULL};
      if (root_ref.kind == KIND_EMPTY) begin
         if (slot_free_top == 0) return o;
         slot_free_top--;
         l = slot_free[slot_free_top];
         slot_digest[l] = d;
         slot_count[l]  = 1;
         slot_live[l]   = 1'b1;
         root_ref = mk_ref(KIND_LEAF, l);
         o = '{handle: l, created: 1'b1, removed: 1'b0, count: 1, status: ST_OK};
         return o;
      end
      cur = root_ref;
      while (cur.kind == KIND_BRANCH)
         cur = node_kid[cur.idx][digest_bit(d, node_crit[cur.idx])];
      l = cur.idx;
      diff = d ^ slot_digest[l];
      if (diff == '0) begin
         if (slot_count[l] < COUNT_TOP) slot_count[l]++;
         o = '{handle: l, created: 1'b0, removed: 1'b0, count: slot_count[l], status: ST_OK};
         return o;
      end
      if (slot_free_top == 0 || node_free_top == 0) return o;
      crit = 0;
      while (!diff[255 - crit]) crit++;
      slot_free_top--;
      l = slot_free[slot_free_top];
      slot_digest[l] = d;
      slot_count[l]  = 1;
      slot_live[l]   = 1'b1;
      node_free_top--;
      nb = node_free[node_free_top];
      node_crit[nb] = 8'(crit);
      s = digest_bit(d, crit);
      // descend to the first branch whose critical bit lies deeper
      parent = -1;
      side   = 0;
      cur    = root_ref;
      while (cur.kind == KIND_BRANCH && node_crit[cur.idx] <= crit) begin
         parent = cur.idx;
         side   = digest_bit(d, node_crit[cur.idx]);
         cur    = node_kid[parent][side];
      end
      leaf = mk_ref(KIND_LEAF, l);
      node_kid[nb][s]     = leaf;
      node_kid[nb][1 - s] = cur;
      set_link(parent, side, mk_ref(KIND_BRANCH, nb));
      o = '{handle: l, created: 1'b1, removed: 1'b0, count: 1, status: ST_OK};
      return o;
   endfunction

   function automatic outcome_t table_release(int h);
      outcome_t  o;
      node_ref_t me;
      node_ref_t cur;
      int b, s, parent, pside;
      o = '{handle: h, created: 1'b0, removed: 1'b0, count: '0, status: ST_DEAD};
      if (!slot_live[h] || slot_count[h] == 0) return o;
      slot_count[h]--;
      o.status = ST_OK;
      if (slot_count[h] != 0) begin
         o.count = slot_count[h];
         return o;
      end
      me = mk_ref(KIND_LEAF, h);
      if (root_ref == me) begin
         root_ref = mk_ref(KIND_EMPTY, 0);
      end else begin
         // find the parent branch, splice the sibling into its place
         parent = -1;
         pside  = 0;
         cur    = root_ref;
         while (cur.kind == KIND_BRANCH) begin
            b = cur.idx;
            s = digest_bit(slot_digest[h], node_crit[b]);
            if (node_kid[b][s] == me) begin
               set_link(parent, pside, node_kid[b][1 - s]);
               node_free[node_free_top++] = b;
               break;
            end
            parent = b;
            pside  = s;
            cur    = node_kid[b][s];
         end
      end
      slot_live[h] = 1'b0;
      slot_free[slot_free_top++] = h;
      o.removed = 1'b1;
      return o;
   endfunction

   function automatic outcome_t queue_request(logic kind, logic [255:0] d, int h);
      request_t q;
      outcome_t o;
      q.kind   = kind;
      q.digest = d;
      q.handle = HANDLE_W'(h);
      o = (kind == REQ_ACQUIRE) ? table_acquire(d) : table_release(h);
      pending_q.push_back(q);
      planned_q.push_back(o);
      return o;
   endfunction

   // a live handle if any, else a random one
   function automatic int pick_live();
      int start;
      start = $urandom_range(0, NUM_SLOTS - 1);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (slot_live[(start + i) % NUM_SLOTS]) return (start + i) % NUM_SLOTS;
      return start;
   endfunction

   // build the stimulus and its expected outcomes
   initial begin
      logic [255:0] base;
      logic [255:0] pool [48];
      logic [255:0] mask;
      outcome_t     o;
      int           r, fulls, h;
      table_clear();

      // directed
      void'(queue_request(REQ_ACQUIRE, '0, 0));
      void'(queue_request(REQ_ACQUIRE, '0, 0));
      void'(queue_request(REQ_ACQUIRE, '1, 1023));
      void'(queue_request(REQ_ACQUIRE, 256'd1, 0));
      void'(queue_request(REQ_ACQUIRE, {1'b1, 255'd0}, 0));
      void'(queue_request(REQ_ACQUIRE, {8'h00, 8'h01, 240'd0}, 0));
      void'(queue_request(REQ_RELEASE, random_digest(), 1023));
      void'(queue_request(REQ_RELEASE, '1, 700));
      void'(queue_request(REQ_RELEASE, '0, 0));
      void'(queue_request(REQ_RELEASE, '0, 0));
      void'(queue_request(REQ_RELEASE, '0, 0));
      void'(queue_request(REQ_RELEASE, '0, 2));
      void'(queue_request(REQ_ACQUIRE, 256'd1, 0));
      void'(queue_request(REQ_ACQUIRE, '0, 0));
      for (int i = 0; i < 5; i++) void'(queue_request(REQ_RELEASE, '0, i));
      o = queue_request(REQ_ACQUIRE, '1, 0);
      void'(queue_request(REQ_RELEASE, '0, o.handle));
      void'(queue_request(REQ_RELEASE, '0, o.handle));

      // keys sharing long prefixes give deep trees
      base = random_digest();
      for (int i = 0; i < 48; i++) begin
         mask = '1 >> $urandom_range(0, 255);
         pool[i] = base ^ (random_digest() & mask);
      end

      // random mix
      while (pending_q.size() < 720) begin
         r = $urandom_range(0, 99);
         if (r < 45)
            void'(queue_request(REQ_ACQUIRE, pool[$urandom_range(0, 47)], $urandom));
         else if (r < 58)
            void'(queue_request(REQ_ACQUIRE, random_digest(), $urandom));
         else if (r < 90)
            void'(queue_request(REQ_RELEASE, random_digest(), pick_live()));
         else
            void'(queue_request(REQ_RELEASE, random_digest(), $urandom_range(0, 1023)));
      end

      // fill the table until it refuses, then churn near full
      fulls = 0;
      while (fulls < 4) begin
         o = queue_request(REQ_ACQUIRE, random_digest(), 0);
         if (o.status == ST_FULL) fulls++;
      end
      while (pending_q.size() < 1850) begin
         r = $urandom_range(0, 99);
         h = pick_live();
         if (r < 40) void'(queue_request(REQ_RELEASE, random_digest(), h));
         else if (r < 50) void'(queue_request(REQ_ACQUIRE, slot_digest[h], 0));
         else void'(queue_request(REQ_ACQUIRE, random_digest(), 0));
      end
      total_items = pending_q.size();
   end

   // reset and end of run
   initial begin
      reset = 1'b1;
      run_over = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      wait (pending_q.size() == 0 && accepted == total_items && awaited_q.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      run_over = 1'b1;
      if (mismatches == 0)
         $display("critbit_tree_refcounted_table_test passed");
      else
         $display("critbit_tree_refcounted_table_test failed");
      $finish;
   end

   // idle rates by progress through the run
   always_comb begin
      if (accepted < total_items / 3) begin
         send_idle = 32;
         take_idle = 54;
      end else if (accepted < 2 * total_items / 3) begin
         send_idle = 54;
         take_idle = 32;
      end else begin
         send_idle = 0;
         take_idle = 0;
      end
   end

   // driver: record each accepted transaction, then present the next
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         accepted   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_q.push_back(shown_outcome);
            accepted <= accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               request_t q;
               q = pending_q.pop_front();
               shown_outcome = planned_q.pop_front();
               req_tdata  <= {5'd0, q.handle, q.digest[63:0], q.digest[127:64],
                              q.digest[191:128], q.digest[255:192], q.kind};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each response with the oldest outstanding outcome
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mismatches <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            outcome_t got;
            outcome_t want;
            got.handle  = rsp_tdata[9:0];
            got.created = rsp_tdata[10];
            got.removed = rsp_tdata[11];
            got.count   = rsp_tdata[27:12];
            got.status  = status_type'(rsp_tdata[29:28]);
            if (awaited_q.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("unexpected response handle %0d status %0d",
                           got.handle, got.status);
            end else begin
               want = awaited_q.pop_front();
               if (got.handle !== want.handle || got.created !== want.created ||
                   got.removed !== want.removed || got.count !== want.count ||
                   got.status !== want.status) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: expected h=%0d c=%b r=%b n=%0d s=%0d, ",
                              "got h=%0d c=%b r=%b n=%0d s=%0d",
                              want.handle, want.created, want.removed, want.count,
                              want.status, got.handle, got.created, got.removed,
                              got.count, got.status);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= take_idle);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (!run_over) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_MAX) begin
            $display("critbit_tree_refcounted_table_test failed");
            $finish;
         end
      end
   end

endmodule
